@@ rtl/core/bfc_pkg.sv @@
// shared constants and types for the brace frame collector
package bfc_pkg;

	// field widths
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned RIDX_W   = 10;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned LEN_W    = 11;
	localparam int unsigned BAL_W    = 12;
	localparam int unsigned CFG_W    = 11;
	localparam int unsigned CFG_IDX_W = 1;

	// item modes
	localparam logic [MODE_W-1:0] MODE_FEED    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_IDLE    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BUSY    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MATCH   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOLD     = 1'd1;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] CAPACITY_RST = 11'd1024;

	// special bytes
	localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

	// saturation limits of the brace balance
	localparam logic signed [BAL_W-1:0] BAL_MAX = 12'sd2047;
	localparam logic signed [BAL_W-1:0] BAL_MIN = -12'sd2048;

	typedef logic [STATUS_W-1:0] status_t;

endpackage

@@ rtl/core/brace_frame_collector_unit.sv @@
// brace frame collector: top level with frame buffer memory and result register
//
// Usage: one item per input transfer (in_valid/in_stall). A feed item hands one
// byte; bytes before the first '{' are dropped, after it every byte goes into the
// frame buffer while the brace balance is tracked. A restart item clears the
// framer; a read item returns the byte at read_index. Each item gives exactly
// one result on the output channel (out_valid/out_stall): status, depth,
// frame_length and read_data.
// The result is registered: it is shown in the cycle after the item is accepted.
// Throughput is one item per cycle unless the receiver stalls, set by the
// single write/read port of the frame buffer, which is touched at most once per item.
// Configuration (capacity, fold_escaped_slash) is written through cfg_we, cfg_index,
// cfg_data; the user must do so only while the block is idle, which it leaves unchecked.
// Reset clears the framer state and the result valid flag and loads the register
// defaults; result payload, last byte and buffer contents stay undefined until written.
// While the receiver stalls, the result register holds its value and in_stall
// is raised, so no item is accepted until the pending result is taken.
module brace_frame_collector_unit #(
	parameter int unsigned BUF_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bfc_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bfc_pkg::MODE_W-1:0]     mode,
	input  logic [bfc_pkg::CHAR_W-1:0]     char_in,
	input  logic [bfc_pkg::RIDX_W-1:0]     read_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bfc_pkg::STATUS_W-1:0]   status,
	output logic [bfc_pkg::LEN_W-1:0]      depth,
	output logic [bfc_pkg::LEN_W-1:0]      frame_length,
	output logic [bfc_pkg::CHAR_W-1:0]     read_data
);

	localparam int unsigned AW   = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int unsigned CW   = $clog2(BUF_DEPTH + 1);
	localparam int unsigned CMPW = (CW > bfc_pkg::LEN_W) ? CW : bfc_pkg::LEN_W;
	localparam int unsigned IW   = (AW > bfc_pkg::RIDX_W) ? AW : bfc_pkg::RIDX_W;
	localparam logic [CW-1:0]   DEPTH_CNT = CW'(BUF_DEPTH);
	localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(BUF_DEPTH);
	localparam logic [IW:0]     DEPTH_IDX = (IW + 1)'(BUF_DEPTH);

	// configuration registers
	logic [bfc_pkg::CFG_W-1:0] capacity_q;
	logic                      fold_q;

	// framer state
	logic                              started_q;
	logic [CW-1:0]                     cnt_q;
	logic signed [bfc_pkg::BAL_W-1:0]  bal_q;
	logic [bfc_pkg::CHAR_W-1:0]        last_q;

	// frame buffer
	logic [bfc_pkg::CHAR_W-1:0] buf_mem [BUF_DEPTH];
	logic [bfc_pkg::CHAR_W-1:0] rd_data_q;
	logic                       rd_hit_q;

	// result register
	logic                         out_valid_q;
	bfc_pkg::status_t             status_q;
	logic [bfc_pkg::LEN_W-1:0]    depth_q;
	logic [bfc_pkg::LEN_W-1:0]    len_q;

	logic                              in_acc;
	logic                              started_n;
	logic [CW-1:0]                     cnt_n;
	logic signed [bfc_pkg::BAL_W-1:0]  bal_n;
	logic signed [bfc_pkg::BAL_W-1:0]  bal_f;
	logic signed [bfc_pkg::BAL_W-1:0]  bal_open;
	logic [bfc_pkg::CHAR_W-1:0]        last_n;
	bfc_pkg::status_t                  status_n;
	logic                              started_f;
	logic                              do_store;
	logic                              do_fold;
	logic                              wr_en;
	logic [AW-1:0]                     wr_addr;
	logic [bfc_pkg::CHAR_W-1:0]        wr_data;
	logic [CMPW-1:0]                   cap_eff;
	logic [CMPW-1:0]                   cap_ext;
	logic [CMPW-1:0]                   cnt_f_ext;
	logic [CMPW-1:0]                   cnt_n_ext;
	logic [CW-1:0]                     cnt_f;
	logic [CW-1:0]                     cnt_dec;
	logic [IW:0]                       idx_ext;
	logic                              rd_en;
	logic [bfc_pkg::BAL_W-1:0]         bal_mag;

	// handshake: take a new item when the result slot is free or being taken
	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	// effective capacity clamped to 1..BUF_DEPTH
	always_comb begin
		cap_ext = CMPW'(capacity_q);
		if (cap_ext == '0) begin
			cap_eff = CMPW'(1);
		end else if (cap_ext > DEPTH_CMP) begin
			cap_eff = DEPTH_CMP;
		end else begin
			cap_eff = cap_ext;
		end
	end

	// read address decode
	assign idx_ext = (IW + 1)'(read_index);
	assign rd_en   = in_acc && (mode == bfc_pkg::MODE_READ) && (idx_ext < DEPTH_IDX);
	assign cnt_dec = cnt_q - CW'(1);

	// feed path: balance, store and fold
	always_comb begin
		started_f = started_q | (char_in == bfc_pkg::CH_OPEN);
		bal_open  = bal_q;
		if (char_in == bfc_pkg::CH_OPEN && bal_q != bfc_pkg::BAL_MAX) begin
			bal_open = bal_q + 12'sd1;
		end
		bal_f = bal_open;
		if (started_f && char_in == bfc_pkg::CH_CLOSE && bal_open != bfc_pkg::BAL_MIN) begin
			bal_f = bal_open - 12'sd1;
		end
		do_store = started_f && (cnt_q != DEPTH_CNT);
		do_fold  = do_store && fold_q && (cnt_q != '0) &&
			(last_q == bfc_pkg::CH_BSLASH) && (char_in == bfc_pkg::CH_SLASH);
		cnt_f = cnt_q;
		if (do_store && !do_fold) begin
			cnt_f = cnt_q + CW'(1);
		end
		cnt_f_ext = CMPW'(cnt_f);
		wr_addr   = do_fold ? cnt_dec[AW-1:0] : cnt_q[AW-1:0];
		wr_data   = do_fold ? bfc_pkg::CH_SLASH : char_in;
	end

	// next framer state and result status per mode
	always_comb begin
		started_n = started_q;
		cnt_n     = cnt_q;
		bal_n     = bal_q;
		last_n    = last_q;
		wr_en     = 1'b0;
		status_n  = bfc_pkg::STAT_IDLE;
		if (mode == bfc_pkg::MODE_FEED) begin
			wr_en     = in_acc && do_store;
			last_n    = do_store ? wr_data : last_q;
			started_n = started_f;
			cnt_n     = cnt_f;
			bal_n     = bal_f;
			if (started_f && bal_f == '0) begin
				status_n = bfc_pkg::STAT_MATCH;
			end else if (cnt_f_ext >= cap_eff) begin
				status_n  = bfc_pkg::STAT_OVERFLOW;
				started_n = 1'b0;
				cnt_n     = '0;
				bal_n     = '0;
			end else begin
				status_n = started_f ? bfc_pkg::STAT_BUSY : bfc_pkg::STAT_IDLE;
			end
		end else if (mode == bfc_pkg::MODE_RESTART) begin
			started_n = 1'b0;
			cnt_n     = '0;
			bal_n     = '0;
			status_n  = bfc_pkg::STAT_IDLE;
		end else begin
			bal_n = bal_q;
			if (started_q && bal_q == '0) begin
				status_n = bfc_pkg::STAT_MATCH;
			end else begin
				status_n = started_q ? bfc_pkg::STAT_BUSY : bfc_pkg::STAT_IDLE;
			end
		end
	end

	// absolute depth, saturated to the output range
	assign bal_mag   = bal_n[bfc_pkg::BAL_W-1] ? unsigned'(-bal_n) : unsigned'(bal_n);
	assign cnt_n_ext = CMPW'(cnt_n);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bfc_pkg::CAPACITY_RST;
			fold_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfc_pkg::REG_CAPACITY: capacity_q <= cfg_data;
				bfc_pkg::REG_FOLD:     fold_q     <= cfg_data[0];
				default:               ;
			endcase
		end
	end

	// framer state update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			cnt_q     <= '0;
			bal_q     <= '0;
		end else if (in_acc) begin
			started_q <= started_n;
			cnt_q     <= cnt_n;
			bal_q     <= bal_n;
		end
	end

	// last stored byte, only meaningful while the count is nonzero
	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_q <= last_n;
		end
	end

	// frame buffer: one write or one read per item, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= buf_mem[idx_ext[AW-1:0]];
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_hit_q    <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
			rd_hit_q    <= rd_en;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q <= status_n;
			depth_q  <= bal_mag[bfc_pkg::BAL_W-1] ? '1 : bal_mag[bfc_pkg::LEN_W-1:0];
			len_q    <= cnt_n_ext[bfc_pkg::LEN_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign depth        = depth_q;
	assign frame_length = len_q;
	assign read_data    = rd_hit_q ? rd_data_q : '0;

	// count never exceeds the buffer
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_CNT)
		else $error("stored count beyond buffer depth");

	// an idle framer holds no bytes and no balance
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> (cnt_q == '0 && bal_q == '0))
		else $error("framer not started but holds state");

	// every accepted item shows a result in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("accepted item gave no result");

	// restart reports an empty, not started framer
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && mode == bfc_pkg::MODE_RESTART) |=>
		(status == bfc_pkg::STAT_IDLE && depth == '0 && frame_length == '0))
		else $error("restart result not cleared");

	// overflow clears length and depth
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == bfc_pkg::STAT_OVERFLOW) |->
		(depth == '0 && frame_length == '0))
		else $error("overflow result not cleared");

	// read data is zero for items that are no in-range read
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && mode != bfc_pkg::MODE_READ) |=> (read_data == '0))
		else $error("read data set on a non-read item");

endmodule

@@ tb/brace_frame_collector_unit_test.sv @@
// self-checking testbench for the brace frame collector unit
module brace_frame_collector_unit_test;

	localparam int unsigned BUF_DEPTH = 1024;
	localparam int unsigned FB_AW = $clog2(BUF_DEPTH);
	localparam int unsigned SHOWN_MISMATCHES = 10;
	localparam logic [bfc_pkg::LEN_W-1:0] DEPTH_LEN = bfc_pkg::LEN_W'(BUF_DEPTH);
	// mode code that the block treats as a no-op read
	localparam logic [bfc_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		bfc_pkg::status_t           status;
		logic [bfc_pkg::LEN_W-1:0]  depth;
		logic [bfc_pkg::LEN_W-1:0]  length;
		logic [bfc_pkg::CHAR_W-1:0] data;
	} frame_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bfc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bfc_pkg::CFG_W-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [bfc_pkg::MODE_W-1:0]    mode;
	logic [bfc_pkg::CHAR_W-1:0]    char_in;
	logic [bfc_pkg::RIDX_W-1:0]    read_index;
	logic                          out_valid;
	logic                          out_stall;
	bfc_pkg::status_t              status;
	logic [bfc_pkg::LEN_W-1:0]     depth;
	logic [bfc_pkg::LEN_W-1:0]     frame_length;
	logic [bfc_pkg::CHAR_W-1:0]    read_data;

	brace_frame_collector_unit #(
		.BUF_DEPTH(BUF_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.char_in(char_in),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.depth(depth),
		.frame_length(frame_length),
		.read_data(read_data)
	);

	// shadow copy of the framer state and registers
	logic [bfc_pkg::CHAR_W-1:0]       fb_mem [BUF_DEPTH];
	logic [bfc_pkg::LEN_W-1:0]        fb_count;
	logic signed [bfc_pkg::BAL_W-1:0] fb_balance;
	logic                             fb_started;
	int unsigned                      fb_written;
	logic [bfc_pkg::CFG_W-1:0]        cap_reg;
	logic                             fold_reg;

	frame_result_t expected_q[$];
	int unsigned   mismatches;
	int unsigned   burst_left;
	int unsigned   stall_hold;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void clear_frame();
		fb_started = 1'b0;
		fb_count = '0;
		fb_balance = '0;
	endfunction

	function automatic logic [bfc_pkg::LEN_W-1:0] usable_capacity();
		if (cap_reg == '0)
			return bfc_pkg::LEN_W'(1);
		if (cap_reg > DEPTH_LEN)
			return DEPTH_LEN;
		return cap_reg;
	endfunction

	function automatic logic [bfc_pkg::LEN_W-1:0] abs_balance();
		int b;
		b = int'(fb_balance);
		if (b < 0)
			b = -b;
		if (b > 2047)
			b = 2047;
		return b[bfc_pkg::LEN_W-1:0];
	endfunction

	function automatic bfc_pkg::status_t frame_state();
		if (fb_started && fb_balance == 0)
			return bfc_pkg::STAT_MATCH;
		return fb_started ? bfc_pkg::STAT_BUSY : bfc_pkg::STAT_IDLE;
	endfunction

	// one byte into the framer: braces, storage, slash folding, overflow
	function automatic bfc_pkg::status_t take_byte(input logic [bfc_pkg::CHAR_W-1:0] c);
		logic [bfc_pkg::LEN_W-1:0] lower;
		logic [bfc_pkg::LEN_W-1:0] upper;
		if (c == bfc_pkg::CH_OPEN) begin
			if (fb_balance < bfc_pkg::BAL_MAX)
				fb_balance = fb_balance + 12'sd1;
			fb_started = 1'b1;
		end
		if (fb_started) begin
			if (c == bfc_pkg::CH_CLOSE && fb_balance > bfc_pkg::BAL_MIN)
				fb_balance = fb_balance - 12'sd1;
			// a full buffer drops the byte
			if (fb_count < DEPTH_LEN) begin
				fb_mem[fb_count[FB_AW-1:0]] = c;
				fb_count = fb_count + bfc_pkg::LEN_W'(1);
				if (32'(fb_count) > fb_written)
					fb_written = 32'(fb_count);
				lower = fb_count - bfc_pkg::LEN_W'(2);
				upper = fb_count - bfc_pkg::LEN_W'(1);
				if (fold_reg && fb_count >= bfc_pkg::LEN_W'(2) &&
				    fb_mem[lower[FB_AW-1:0]] == bfc_pkg::CH_BSLASH &&
				    fb_mem[upper[FB_AW-1:0]] == bfc_pkg::CH_SLASH) begin
					fb_mem[lower[FB_AW-1:0]] = bfc_pkg::CH_SLASH;
					fb_count = fb_count - bfc_pkg::LEN_W'(1);
				end
			end
		end
		// a match wins over overflow
		if (fb_started && fb_balance == 0)
			return bfc_pkg::STAT_MATCH;
		if (fb_count >= usable_capacity()) begin
			clear_frame();
			return bfc_pkg::STAT_OVERFLOW;
		end
		return fb_started ? bfc_pkg::STAT_BUSY : bfc_pkg::STAT_IDLE;
	endfunction

	function automatic frame_result_t predict_item(input logic [bfc_pkg::MODE_W-1:0] m,
			input logic [bfc_pkg::CHAR_W-1:0] c, input logic [bfc_pkg::RIDX_W-1:0] idx);
		frame_result_t r;
		r.data = '0;
		unique case (m)
			bfc_pkg::MODE_FEED: r.status = take_byte(c);
			bfc_pkg::MODE_RESTART: begin
				clear_frame();
				r.status = bfc_pkg::STAT_IDLE;
			end
			bfc_pkg::MODE_READ: begin
				r.data = fb_mem[idx];
				r.status = frame_state();
			end
			default: r.status = frame_state();
		endcase
		r.depth = abs_balance();
		r.length = fb_count;
		return r;
	endfunction

	// one input transfer, with bursts and random gaps in between
	task automatic send_item(input logic [bfc_pkg::MODE_W-1:0] m,
			input logic [bfc_pkg::CHAR_W-1:0] c, input logic [bfc_pkg::RIDX_W-1:0] idx);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= m;
		char_in <= c;
		read_index <= idx;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(predict_item(m, c, idx));
	endtask

	// hold the sender until every pending result has arrived
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bfc_pkg::CFG_IDX_W-1:0] idx,
			input logic [bfc_pkg::CFG_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bfc_pkg::REG_CAPACITY)
			cap_reg = value;
		else
			fold_reg = value[0];
	endtask

	// mostly well-formed frames with random content, some noise
	task automatic send_framed_traffic(input int unsigned n);
		int unsigned                done;
		int unsigned                r;
		logic [bfc_pkg::MODE_W-1:0] m;
		logic [bfc_pkg::CHAR_W-1:0] c;
		logic [bfc_pkg::RIDX_W-1:0] idx;
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 99);
			m = bfc_pkg::MODE_FEED;
			c = bfc_pkg::CHAR_W'($urandom);
			idx = bfc_pkg::RIDX_W'($urandom);
			if (r < 8) begin
				m = bfc_pkg::MODE_W'($urandom_range(0, 3));
			end else if (!fb_started) begin
				if (r < 75)
					c = bfc_pkg::CH_OPEN;
			end else if (frame_state() == bfc_pkg::STAT_MATCH && r < 60) begin
				m = bfc_pkg::MODE_RESTART;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3)
					m = bfc_pkg::MODE_RESTART;
				else if (r < 15)
					m = bfc_pkg::MODE_READ;
				else if (r < 17)
					m = MODE_SPARE;
				else if (r < 37)
					c = bfc_pkg::CH_OPEN;
				else if (r < 60)
					c = bfc_pkg::CH_CLOSE;
				else if (r < 68)
					c = bfc_pkg::CH_BSLASH;
				else if (r < 76)
					c = bfc_pkg::CH_SLASH;
			end
			// reads stay within entries that have been written
			if (m == bfc_pkg::MODE_READ) begin
				if (fb_written == 0)
					m = MODE_SPARE;
				else
					idx = bfc_pkg::RIDX_W'($urandom_range(0, fb_written - 1));
			end
			if (m != bfc_pkg::MODE_FEED || fb_started || c == bfc_pkg::CH_OPEN)
				done++;
			send_item(m, c, idx);
			if ($urandom_range(0, 39) == 0)
				drain_results();
		end
	endtask

	// idle bytes, a nested frame with a match, reads, restart, spare mode
	task automatic test_basic_framing();
		send_item(MODE_SPARE, 8'h00, 10'h3FF);
		send_item(bfc_pkg::MODE_FEED, 8'h00, 10'h000);
		send_item(bfc_pkg::MODE_FEED, 8'hFF, 10'h3FF);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_CLOSE, 10'h000);
		send_item(bfc_pkg::MODE_RESTART, 8'hFF, 10'h3FF);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_BSLASH, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_SLASH, 10'h000);
		send_item(bfc_pkg::MODE_FEED, 8'hFF, 10'h000);
		send_item(bfc_pkg::MODE_FEED, 8'h00, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_CLOSE, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_CLOSE, 10'h000);
		send_item(bfc_pkg::MODE_READ, 8'h00, 10'd0);
		send_item(bfc_pkg::MODE_READ, 8'hFF, 10'd3);
		// bytes after a match keep the frame matched
		send_item(bfc_pkg::MODE_FEED, 8'h41, 10'h000);
		// a close after a match drives the balance negative
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_CLOSE, 10'h000);
		send_item(bfc_pkg::MODE_READ, 8'h00, 10'd8);
		send_item(bfc_pkg::MODE_RESTART, 8'h00, 10'h000);
		// restart keeps buffer contents
		send_item(bfc_pkg::MODE_READ, 8'h00, 10'd1);
		send_item(MODE_SPARE, 8'hFF, 10'd0);
	endtask

	task automatic test_slash_folding();
		write_reg(bfc_pkg::REG_FOLD, bfc_pkg::CFG_W'(1));
		send_item(bfc_pkg::MODE_RESTART, 8'h00, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_BSLASH, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_SLASH, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_BSLASH, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_BSLASH, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_SLASH, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_SLASH, 10'h000);
		send_item(bfc_pkg::MODE_READ, 8'h00, 10'd1);
		send_item(bfc_pkg::MODE_READ, 8'h00, 10'd3);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_CLOSE, 10'h000);
		send_item(bfc_pkg::MODE_RESTART, 8'h00, 10'h000);
		write_reg(bfc_pkg::REG_FOLD, bfc_pkg::CFG_W'(0));
	endtask

	// zero and one capacity, match at capacity, clamp, capacity lowered mid-frame
	task automatic test_capacity_limits();
		write_reg(bfc_pkg::REG_CAPACITY, 11'd0);
		send_item(bfc_pkg::MODE_RESTART, 8'h00, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, 10'h000);
		write_reg(bfc_pkg::REG_CAPACITY, 11'd1);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, 10'h000);
		write_reg(bfc_pkg::REG_CAPACITY, 11'd2);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_CLOSE, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, 10'h000);
		write_reg(bfc_pkg::REG_CAPACITY, 11'd2047);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, 10'h000);
		send_item(bfc_pkg::MODE_FEED, 8'h61, 10'h000);
		send_item(bfc_pkg::MODE_FEED, 8'h62, 10'h000);
		write_reg(bfc_pkg::REG_CAPACITY, 11'd3);
		send_item(bfc_pkg::MODE_READ, 8'h00, 10'd0);
		send_item(MODE_SPARE, 8'h00, 10'h000);
		send_item(bfc_pkg::MODE_FEED, 8'h63, 10'h000);
		write_reg(bfc_pkg::REG_CAPACITY, 11'd1024);
	endtask

	// fill every entry under a matched frame, then feed past the end
	task automatic test_full_buffer();
		logic [bfc_pkg::CHAR_W-1:0] c;
		write_reg(bfc_pkg::REG_FOLD, bfc_pkg::CFG_W'(0));
		send_item(bfc_pkg::MODE_RESTART, 8'h00, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, 10'h000);
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_CLOSE, 10'h000);
		repeat (BUF_DEPTH - 3) begin
			do c = bfc_pkg::CHAR_W'($urandom);
			while (c == bfc_pkg::CH_OPEN || c == bfc_pkg::CH_CLOSE);
			send_item(bfc_pkg::MODE_FEED, c, bfc_pkg::RIDX_W'($urandom));
		end
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_BSLASH, 10'h000);
		send_item(bfc_pkg::MODE_FEED, 8'h61, 10'h000);
		// no folding once the buffer is full
		write_reg(bfc_pkg::REG_FOLD, bfc_pkg::CFG_W'(1));
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_SLASH, 10'h000);
		send_item(bfc_pkg::MODE_READ, 8'h00, 10'd1023);
		send_item(bfc_pkg::MODE_READ, 8'h00, 10'd512);
		repeat (16)
			send_item(bfc_pkg::MODE_READ, bfc_pkg::CHAR_W'($urandom),
				bfc_pkg::RIDX_W'($urandom));
		send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, 10'h000);
		write_reg(bfc_pkg::REG_FOLD, bfc_pkg::CFG_W'(0));
	endtask

	// nesting grows until the buffer reaches capacity
	task automatic test_deep_nesting();
		write_reg(bfc_pkg::REG_CAPACITY, 11'd16);
		send_item(bfc_pkg::MODE_RESTART, 8'h00, 10'h000);
		repeat (17)
			send_item(bfc_pkg::MODE_FEED, bfc_pkg::CH_OPEN, bfc_pkg::RIDX_W'($urandom));
		send_item(MODE_SPARE, bfc_pkg::CHAR_W'($urandom), bfc_pkg::RIDX_W'($urandom));
	endtask

	task automatic test_random_phases();
		int unsigned cap;
		int unsigned n;
		for (int p = 0; p < 6; p++) begin
			unique case (p)
				0: begin cap = $urandom_range(3, 16); n = 30; end
				1: begin cap = $urandom_range(17, 64); n = 30; end
				2: begin cap = 1024; n = 30; end
				3: begin cap = 2047; n = 25; end
				4: begin cap = $urandom_range(65, 400); n = 30; end
				default: begin cap = 0; n = 10; end
			endcase
			write_reg(bfc_pkg::REG_CAPACITY, cap[bfc_pkg::CFG_W-1:0]);
			write_reg(bfc_pkg::REG_FOLD, bfc_pkg::CFG_W'($urandom_range(0, 1)));
			send_framed_traffic(n);
		end
	endtask

	// result check and receiver stall pattern
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			got = '{status, depth, frame_length, read_data};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected result transfer: status %0d depth %0d",
						" length %0d data %02h",
						got.status, got.depth, got.length, got.data);
			end else begin
				want = expected_q.pop_front();
				if (got.status !== want.status || got.depth !== want.depth ||
				    got.length !== want.length || got.data !== want.data) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES)
						$display("mismatch: expected status %0d depth %0d length %0d",
							" data %02h,", want.status, want.depth, want.length,
							want.data, " got status %0d depth %0d length %0d",
							" data %02h", got.status, got.depth, got.length, got.data);
				end
			end
		end
		if (stall_hold != 0) begin
			stall_hold--;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(0, 10);
		end else begin
			out_stall <= 1'b1;
			stall_hold = $urandom_range(0, 5);
		end
	end

	// reset, tests in turn, final verdict
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= bfc_pkg::REG_CAPACITY;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= bfc_pkg::MODE_FEED;
		char_in <= '0;
		read_index <= '0;
		out_stall <= 1'b0;
		stall_hold = 0;
		burst_left = 0;
		mismatches = 0;
		fb_written = 0;
		clear_frame();
		cap_reg = bfc_pkg::CAPACITY_RST;
		fold_reg = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_framing();
		test_slash_folding();
		test_capacity_limits();
		test_full_buffer();
		test_deep_nesting();
		test_random_phases();

		drain_results();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
